/* sv/assert_macros.svh */
// Assertion macros for the port-level checker of the level meter.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define CHK_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define CHK_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pdlm_pkg.sv */
// Shared types and constants of the peak decay level meter.
// No dependencies; every module of the meter imports it.
package pdlm_pkg;

  localparam int PEAK_W     = 16;
  localparam int FALL_W     = 14;
  localparam int LVL_W      = 16;
  localparam int TOP_W      = 15;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int E_W        = 4;

  // Request codes carried on tuser
  localparam logic [REQ_W-1:0] REQ_UPDATE     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INVALIDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESET      = 2'd2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_METER_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BAR_PX   = 3'd4;

  // Register reset values
  localparam logic [LVL_W-1:0] FLOOR_RST        = 16'hA000;  // -24576
  localparam logic [LVL_W-1:0] SCALE_BOTTOM_RST = 16'hC400;  // -15360
  localparam logic [TOP_W-1:0] SCALE_TOP_RST    = 15'd1536;
  localparam int               METER_HEIGHT_RST = 200;
  localparam int               MIN_BAR_PX_RST   = 2;

  // Peak saturation value
  localparam logic [PEAK_W-1:0] PEAK_MAX = 16'd32768;

  // log2 by repeated squaring: Q30 mantissa, 24 fraction bits
  localparam int MANT_W   = 31;
  localparam int LOG_FRAC = 24;
  localparam int N_W      = E_W + LOG_FRAC;

  // 20*log10(2) in Q32, split into two partial-product coefficients
  localparam int               DB_K_LO_W = 18;
  localparam logic [34:0]      DB_K_Q32  = 35'd25858279730;
  localparam logic [DB_K_LO_W-1:0] DB_K_LO = DB_K_Q32[DB_K_LO_W-1:0];
  localparam logic [DB_K_LO_W-1:0] DB_K_HI = {1'b0, DB_K_Q32[34:DB_K_LO_W]};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_MUL,
    ST_HOLD,
    ST_BAR_GO,
    ST_BAR,
    ST_DONE
  } pdlm_state_t;

endpackage

/* sv/pdlm_log2.sv */
// Serial log2 unit: normalises the peak, then squares the mantissa once per
// cycle and shifts one fraction bit per step into a shift register. Uses pdlm_pkg.
module pdlm_log2
  import pdlm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PEAK_W-1:0] peak,
  output logic              done,
  output logic [N_W-1:0]    n_log   // |log2(peak/32768)| in Q24
);

  localparam int CNT_W = $clog2(LOG_FRAC);
  localparam logic [4:0] TOP_BIT = 5'(MANT_W - 1);

  logic [PEAK_W-1:0]     pc;
  logic [E_W-1:0]        e;
  logic [MANT_W-1:0]     m_init;
  logic [2*MANT_W-1:0]   sq;
  logic [MANT_W:0]       sq_t;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [MANT_W-1:0]     mant;
  logic [LOG_FRAC-1:0]   frac;
  logic [E_W-1:0]        ipart;

  always_comb begin
    pc = (peak > PEAK_MAX) ? PEAK_MAX : peak;
    e  = '0;
    for (int i = 1; i < PEAK_W; i++) begin
      if (pc[i]) begin
        e = E_W'(i);
      end
    end
    m_init = MANT_W'(pc) << (TOP_BIT - {1'b0, e});
    sq     = {{MANT_W{1'b0}}, mant} * {{MANT_W{1'b0}}, mant};
    sq_t   = sq[2*MANT_W-1:MANT_W-1];
  end

  assign n_log = {ipart, {LOG_FRAC{1'b0}}} - N_W'(frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(LOG_FRAC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mant  <= m_init;
      frac  <= '0;
      ipart <= E_W'(PEAK_W - 1) - e;
    end else if (busy) begin
      // square reached 2.0: halve and emit a one
      if (sq_t[MANT_W]) begin
        mant <= sq_t[MANT_W:1];
        frac <= {frac[LOG_FRAC-2:0], 1'b1};
      end else begin
        mant <= sq_t[MANT_W-1:0];
        frac <= {frac[LOG_FRAC-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/pdlm_db_conv.sv */
// Converts the Q24 log2 magnitude to dBFS: two partial products of N*K,
// round half away from zero, cap and negate. Uses pdlm_pkg.
module pdlm_db_conv
  import pdlm_pkg::*;
#(
  parameter int DB_FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [N_W-1:0]   n_log,
  output logic             done,
  output logic [LVL_W-1:0] db_level
);

  localparam int          SH     = 56 - DB_FRAC_BITS;
  localparam logic [63:0] RND    = 64'd1 << (SH - 1);
  localparam int          PROD_W = N_W + DB_K_LO_W;
  localparam logic [LVL_W:0] MAG_MAX = 17'd32768;

  logic                 busy;
  logic [1:0]           step;
  logic [DB_K_LO_W-1:0] coef;
  logic [PROD_W-1:0]    prod_c;
  logic [PROD_W-1:0]    prod;
  logic [63:0]          acc;
  logic [63:0]          mag;
  logic [LVL_W:0]       mag_c;
  logic [LVL_W:0]       neg;

  always_comb begin
    coef   = (step == 2'd0) ? DB_K_LO : DB_K_HI;
    prod_c = {{DB_K_LO_W{1'b0}}, n_log} * {{N_W{1'b0}}, coef};
    mag    = acc >> SH;
    mag_c  = (mag > 64'(MAG_MAX)) ? MAG_MAX : mag[LVL_W:0];
    neg    = '0 - mag_c;
  end

  assign db_level = neg[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      case (step)
        2'd0: begin
          prod <= prod_c;
        end
        2'd1: begin
          acc  <= 64'(prod) + RND;
          prod <= prod_c;
        end
        default: begin
          // add the high partial product at its weight
          acc <= acc + (64'(prod) << DB_K_LO_W);
        end
      endcase
    end
  end

endmodule

/* sv/pdlm_bar_scale.sv */
// Bar scaling unit: one multiply, then a restoring divider that yields one
// quotient bit per cycle, cap and minimum-bar test. Uses pdlm_pkg.
module pdlm_bar_scale
  import pdlm_pkg::*;
#(
  parameter int PX_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [LVL_W-1:0] level,
  input  logic signed [LVL_W-1:0] scale_bottom,
  input  logic signed [TOP_W-1:0] scale_top,
  input  logic [PX_BITS-1:0]      meter_height,
  input  logic [PX_BITS-1:0]      min_bar_px,
  output logic                    done,
  output logic [PX_BITS-1:0]      bar_px
);

  localparam int PROD_W = LVL_W + PX_BITS;
  localparam int REM_W  = PX_BITS + 19;
  localparam int DVS_W  = LVL_W + 1;
  localparam int CNT_W  = $clog2(PX_BITS + 1);

  logic [LVL_W:0]       span_c;
  logic [LVL_W:0]       diff_c;
  logic                 above;
  logic                 span_pos;
  logic [PROD_W-1:0]    prod_c;
  logic [REM_W-1:0]     nm_c;
  logic [DVS_W-1:0]     dvs;
  logic [REM_W-1:0]     dlim;
  logic                 ge;
  logic [PX_BITS-1:0]   base;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [PROD_W-1:0]    prod;
  logic [REM_W-1:0]     rem;
  logic [REM_W-1:0]     dsh;
  logic [PX_BITS-1:0]   q;
  logic                 ovf;

  always_comb begin
    span_c   = {{2{scale_top[TOP_W-1]}}, scale_top}
             - {scale_bottom[LVL_W-1], scale_bottom};
    diff_c   = {level[LVL_W-1], level} - {scale_bottom[LVL_W-1], scale_bottom};
    above    = level > scale_bottom;
    span_pos = !span_c[LVL_W] && (span_c != '0);
    prod_c   = {{PX_BITS{1'b0}}, diff_c[LVL_W-1:0]} * {{LVL_W{1'b0}}, meter_height};
    // numerator 2*num + span over divisor 2*span gives half-up rounding
    nm_c     = REM_W'({prod, 1'b0}) + REM_W'(span_c[LVL_W-1:0]);
    dvs      = {span_c[LVL_W-1:0], 1'b0};
    dlim     = REM_W'(dvs) << PX_BITS;
    ge       = rem >= dsh;
    base     = (!span_pos || ovf || (q > meter_height)) ? meter_height : q;
    bar_px   = (!above || (base < min_bar_px)) ? '0 : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PX_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= prod_c;
    end else if (busy) begin
      if (cnt == '0) begin
        rem <= nm_c;
        dsh <= REM_W'(dvs) << (PX_BITS - 1);
        ovf <= nm_c >= dlim;
      end else begin
        if (ge) begin
          rem <= rem - dsh;
        end
        dsh <= dsh >> 1;
        q   <= {q[PX_BITS-2:0], ge};
      end
    end
  end

endmodule

/* sv/peak_decay_level_meter.sv */
// Peak decay level meter. An update with a non-zero peak runs the 24-step
// squaring loop of the log unit, the dB conversion and the bit-per-cycle bar
// divider; a zero peak skips the log and dB units, other requests go straight
// to the result. No new item is taken until the result is in the output
// register. Synchronous reset restores the register defaults, the floor as
// held level and a valid empty bar.
module peak_decay_level_meter
  import pdlm_pkg::*;
#(
  parameter int DB_FRAC_BITS = 8,
  parameter int PX_BITS      = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // peak, fall_step
  input  logic [REQ_W-1:0]                  s_tuser,   // req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // target_level, held_level, bar_px, bar_changed
  output logic [((PX_BITS+40)/8)*8-1:0]     m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data
);

  localparam int OUT_W = ((PX_BITS + 40) / 8) * 8;
  localparam int RES_W = 2 * LVL_W + PX_BITS + 1;

  pdlm_state_t state, state_next;

  logic [LVL_W-1:0]   floor_level;
  logic [LVL_W-1:0]   scale_bottom;
  logic [TOP_W-1:0]   scale_top;
  logic [PX_BITS-1:0] meter_height;
  logic [PX_BITS-1:0] min_bar_px;

  logic [LVL_W-1:0]   level_hold;
  logic [PX_BITS-1:0] shown_px;
  logic               shown_valid;

  logic [REQ_W-1:0]   req_q;
  logic [FALL_W-1:0]  fall_q;
  logic               zero_q;
  logic [LVL_W-1:0]   target_q;

  logic [PEAK_W-1:0]  peak_in;
  logic               log_start, log_done;
  logic [N_W-1:0]     n_log;
  logic               db_start, db_done;
  logic [LVL_W-1:0]   db_level;
  logic               bar_start, bar_done;
  logic [PX_BITS-1:0] bar_px_u;
  logic               fin;

  logic [LVL_W-1:0]        tgt_c;
  logic signed [LVL_W+1:0] tgt18, fallen, floor18, lvl_a, lvl_c;

  logic [LVL_W-1:0]   res_target, res_held;
  logic [PX_BITS-1:0] res_px;
  logic               res_changed;

  assign peak_in   = s_tdata[PEAK_W-1:0];
  assign cfg_ready = 1'b1;

  pdlm_log2 u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .peak  (peak_in),
    .done  (log_done),
    .n_log (n_log)
  );

  pdlm_db_conv #(
    .DB_FRAC_BITS (DB_FRAC_BITS)
  ) u_db_conv (
    .clk      (clk),
    .rst      (rst),
    .start    (db_start),
    .n_log    (n_log),
    .done     (db_done),
    .db_level (db_level)
  );

  pdlm_bar_scale #(
    .PX_BITS (PX_BITS)
  ) u_bar_scale (
    .clk          (clk),
    .rst          (rst),
    .start        (bar_start),
    .level        (level_hold),
    .scale_bottom (scale_bottom),
    .scale_top    (scale_top),
    .meter_height (meter_height),
    .min_bar_px   (min_bar_px),
    .done         (bar_done),
    .bar_px       (bar_px_u)
  );

  // Next state and sequencing
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    log_start  = 1'b0;
    db_start   = 1'b0;
    bar_start  = 1'b0;
    fin        = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == REQ_UPDATE) begin
            if (peak_in == '0) begin
              state_next = ST_HOLD;
            end else begin
              log_start  = 1'b1;
              state_next = ST_LOG;
            end
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_LOG: begin
        if (log_done) begin
          db_start   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (db_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        state_next = ST_BAR_GO;
      end
      ST_BAR_GO: begin
        bar_start  = 1'b1;
        state_next = ST_BAR;
      end
      ST_BAR: begin
        if (bar_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the finished result until the output register is free
        if (!m_tvalid || m_tready) begin
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Held level after decay and floor clamp
  always_comb begin
    tgt_c   = zero_q ? floor_level : db_level;
    tgt18   = {{2{tgt_c[LVL_W-1]}}, tgt_c};
    floor18 = {{2{floor_level[LVL_W-1]}}, floor_level};
    fallen  = {{2{level_hold[LVL_W-1]}}, level_hold} - {4'b0, fall_q};
    lvl_a   = (tgt18 > fallen) ? tgt18 : fallen;
    lvl_c   = (lvl_a < floor18) ? floor18 : lvl_a;
  end

  // Result fields per request
  always_comb begin
    res_target  = floor_level;
    res_held    = floor_level;
    res_px      = '0;
    res_changed = 1'b0;
    case (req_q)
      REQ_UPDATE: begin
        res_target  = target_q;
        res_held    = level_hold;
        res_px      = bar_px_u;
        res_changed = !shown_valid || (bar_px_u != shown_px);
      end
      REQ_INVALIDATE: begin
        res_changed = 1'b0;
      end
      REQ_RESET: begin
        res_changed = !shown_valid || (shown_px != '0);
      end
      default: begin
        res_held = level_hold;
        res_px   = shown_px;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      floor_level  <= FLOOR_RST;
      scale_bottom <= SCALE_BOTTOM_RST;
      scale_top    <= SCALE_TOP_RST;
      meter_height <= PX_BITS'(METER_HEIGHT_RST);
      min_bar_px   <= PX_BITS'(MIN_BAR_PX_RST);
      level_hold   <= FLOOR_RST;
      shown_px     <= '0;
      shown_valid  <= 1'b1;
    end else begin
      state <= state_next;

      if (fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          REG_FLOOR_LEVEL:  floor_level  <= cfg_data;
          REG_SCALE_BOTTOM: scale_bottom <= cfg_data;
          REG_SCALE_TOP:    scale_top    <= cfg_data[TOP_W-1:0];
          REG_METER_HEIGHT: meter_height <= cfg_data[PX_BITS-1:0];
          REG_MIN_BAR_PX:   min_bar_px   <= cfg_data[PX_BITS-1:0];
          default: begin
          end
        endcase
      end

      if (state == ST_HOLD) begin
        level_hold <= lvl_c[LVL_W-1:0];
      end else if (fin && ((req_q == REQ_INVALIDATE) || (req_q == REQ_RESET))) begin
        level_hold <= floor_level;
      end

      if (fin) begin
        case (req_q)
          REQ_UPDATE: begin
            shown_px    <= bar_px_u;
            shown_valid <= 1'b1;
          end
          REQ_INVALIDATE: begin
            shown_valid <= 1'b0;
          end
          REQ_RESET: begin
            shown_px    <= '0;
            shown_valid <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q  <= s_tuser;
      fall_q <= s_tdata[PEAK_W+FALL_W-1:PEAK_W];
      zero_q <= (peak_in == '0);
    end
    if (state == ST_HOLD) begin
      target_q <= tgt_c;
    end
    if (fin) begin
      m_tdata <= OUT_W'(RES_W'({res_changed, res_px, res_held, res_target}));
    end
  end

endmodule

/* sv/pdlm_checker.sv */
// Port-level checker for the level meter, bound to the top level below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pdlm_checker #(
  parameter int PX_BITS = 10
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [((PX_BITS+40)/8)*8-1:0] m_tdata
);

  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `CHK_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while a transaction is in work")
  `CHK_IMPL(a_result_from_busy, clk, rst, $rose(m_tvalid), $past(!s_tready), "result appeared with no transaction in work")
  `CHK_NEXT(a_no_overrun, clk, rst, m_tvalid && !m_tready && !s_tready, !s_tready, "engine freed while result still waits")

endmodule

bind peak_decay_level_meter pdlm_checker #(.PX_BITS(PX_BITS)) u_pdlm_checker (.*);

/* sim/level_meter_checker.sv */
// Checker for the peak decay level meter: watches the request, result and register channels,
// predicts each reading and compares it field by field. Depends on pdlm_pkg.
module level_meter_checker
  import pdlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [31:0]           s_tdata,
  input  logic [REQ_W-1:0]      s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [47:0]           m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_cnt,
  output int                    outstanding
);

  typedef struct packed {
    logic [15:0] target;
    logic [15:0] held;
    logic [9:0]  bar;
    logic        changed;
  } reading_t;

  // 20*log10(2) in Q32; log magnitude is Q24, so shift by 56 - 8 fraction bits
  localparam longint unsigned DB_PER_OCTAVE_Q32 = 64'd25858279730;
  localparam int              DB_SHIFT          = 48;

  int        floor_q, bottom_q, top_q, height_q, min_px_q;
  int        hold_q;
  logic [9:0] shown_q;
  logic       shown_ok;
  reading_t   readings[$];
  reading_t   want, got;
  int         errs = 0;

  assign fail_cnt = errs;

  function automatic int dbfs_of_peak(logic [15:0] pk);
    int unsigned     p;
    int              e, i;
    longint unsigned mant, frac, n, mag;
    if (pk == 16'd0) return floor_q;
    p = (pk > 16'd32768) ? 32'd32768 : {16'd0, pk};
    e = 0;
    while ((p >> (e + 1)) != 0) e++;
    mant = {32'd0, p} << (30 - e);
    frac = 0;
    // log2 fraction by repeated squaring of the Q30 mantissa
    for (i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    n = (64'(15 - e) << 24) - frac;
    mag = (n * DB_PER_OCTAVE_Q32 + (64'd1 << (DB_SHIFT - 1))) >> DB_SHIFT;
    if (mag > 64'd32768) mag = 64'd32768;
    return -int'(mag);
  endfunction

  function automatic logic [9:0] bar_of_level(int lvl);
    int              span;
    longint unsigned num, px;
    span = top_q - bottom_q;
    if (lvl <= bottom_q) return 10'd0;
    if (span <= 0) begin
      px = 64'(height_q);
    end else begin
      num = 64'(lvl - bottom_q) * 64'(height_q);
      px = (2 * num + 64'(span)) / (2 * 64'(span));
      if (px > 64'(height_q)) px = 64'(height_q);
    end
    if (px < 64'(min_px_q)) px = 0;
    return px[9:0];
  endfunction

  function automatic reading_t next_reading(logic [1:0] req, logic [15:0] pk,
                                            logic [13:0] fall);
    reading_t   r;
    int         tgt, fallen, lvl;
    logic [9:0] px;
    logic       chg;
    tgt = floor_q;
    px  = '0;
    chg = 1'b0;
    case (req)
      REQ_UPDATE: begin
        fallen = hold_q - int'({18'd0, fall});
        tgt = dbfs_of_peak(pk);
        lvl = (tgt > fallen) ? tgt : fallen;
        if (lvl < floor_q) lvl = floor_q;
        hold_q = lvl;
        px = bar_of_level(lvl);
        chg = !shown_ok || (px != shown_q);
        shown_q = px;
        shown_ok = 1'b1;
      end
      REQ_INVALIDATE: begin
        shown_ok = 1'b0;
        hold_q = floor_q;
      end
      REQ_RESET: begin
        hold_q = floor_q;
        chg = !shown_ok || (shown_q != 10'd0);
        shown_q = '0;
        shown_ok = 1'b1;
      end
      default: px = shown_q;
    endcase
    r.target  = tgt[15:0];
    r.held    = hold_q[15:0];
    r.bar     = px;
    r.changed = chg;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      floor_q  = int'($signed(FLOOR_RST));
      bottom_q = int'($signed(SCALE_BOTTOM_RST));
      top_q    = int'($signed(SCALE_TOP_RST));
      height_q = METER_HEIGHT_RST;
      min_px_q = MIN_BAR_PX_RST;
      hold_q   = floor_q;
      shown_q  = '0;
      shown_ok = 1'b1;
      readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FLOOR_LEVEL:  floor_q  = int'($signed(cfg_data));
          REG_SCALE_BOTTOM: bottom_q = int'($signed(cfg_data));
          REG_SCALE_TOP:    top_q    = int'($signed(cfg_data[TOP_W-1:0]));
          REG_METER_HEIGHT: height_q = int'(cfg_data[9:0]);
          REG_MIN_BAR_PX:   min_px_q = int'(cfg_data[9:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        readings.push_back(next_reading(s_tuser, s_tdata[15:0], s_tdata[29:16]));
      if (m_tvalid && m_tready) begin
        got.target  = m_tdata[15:0];
        got.held    = m_tdata[31:16];
        got.bar     = m_tdata[41:32];
        got.changed = m_tdata[42];
        if (readings.size() == 0) begin
          $error("result transaction with no request pending");
          errs++;
        end else begin
          want = readings.pop_front();
          if (got.target !== want.target) begin
            $error("target_level: expected %0d, got %0d",
                   $signed(want.target), $signed(got.target));
            errs++;
          end
          if (got.held !== want.held) begin
            $error("held_level: expected %0d, got %0d",
                   $signed(want.held), $signed(got.held));
            errs++;
          end
          if (got.bar !== want.bar) begin
            $error("bar_px: expected %0d, got %0d", want.bar, got.bar);
            errs++;
          end
          if (got.changed !== want.changed) begin
            $error("bar_changed: expected %0d, got %0d", want.changed, got.changed);
            errs++;
          end
        end
      end
    end
    outstanding <= readings.size();
  end

endmodule

/* sim/testbench.sv */
// Top of the level meter bench: clock, reset, request and register stimulus, receiver stalls.
// Instantiates peak_decay_level_meter and level_meter_checker; uses pdlm_pkg.
module testbench;
  import pdlm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int LIMIT       = 1000000;
  localparam int LONG_STALL  = 400;
  localparam int SETTLE      = 100;
  localparam int PHASE_ITEMS = 100;
  localparam int N_PHASES    = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [47:0]           m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int          fail_cnt, outstanding;
  int          src_idle = 0;
  int          sink_idle = 0;
  int          stall_left = 0;
  logic        stall_req = 1'b0;
  logic        stall_taken = 1'b0;
  int          cycles = 0;
  logic [15:0] last_peak = '0;

  peak_decay_level_meter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  level_meter_checker meter_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_cnt    (fail_cnt),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off once requested
  always @(posedge clk) begin
    if (stall_req && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left  <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
    m_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= sink_idle);
  end

  task automatic offer(input logic [REQ_W-1:0] req, input logic [15:0] pk,
                       input logic [13:0] fall);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {2'b00, fall, pk};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and hold until every reading has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input int fl, input int bt, input int tp, input int ht,
                               input int mp);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    int                    i;
    idx[0] = REG_FLOOR_LEVEL;  val[0] = 16'(fl);
    idx[1] = REG_SCALE_BOTTOM; val[1] = 16'(bt);
    idx[2] = REG_SCALE_TOP;    val[2] = 16'(tp);
    idx[3] = REG_METER_HEIGHT; val[3] = 16'(ht);
    idx[4] = REG_MIN_BAR_PX;   val[4] = 16'(mp);
    cfg_valid <= 1'b1;
    for (i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item;
    int               r;
    logic [REQ_W-1:0] req;
    logic [15:0]      pk;
    logic [13:0]      fall;
    r    = $urandom_range(0, 99);
    req  = REQ_UPDATE;
    pk   = 16'($urandom());
    fall = 14'($urandom());
    if (r < 60) begin
      case ($urandom_range(0, 9))
        0:       pk = '0;
        1:       pk = 16'($urandom_range(1, 15));
        2:       pk = 16'($urandom_range(16, 1023));
        3:       pk = 16'($urandom_range(32700, 32768));
        4:       pk = 16'($urandom_range(32769, 65535));
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0:       fall = '0;
        1:       fall = 14'($urandom_range(1, 64));
        2:       fall = 14'($urandom_range(0, 1023));
        default: ;
      endcase
    end else if (r < 78) begin
      // repeat the last peak so the bar often stays put
      pk   = last_peak;
      fall = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(0, 31));
    end else if (r < 87) begin
      req = REQ_INVALIDATE;
    end else if (r < 96) begin
      req = REQ_RESET;
    end else begin
      req = REQ_SPARE;
    end
    if (req == REQ_UPDATE) last_peak = pk;
    offer(req, pk, fall);
  endtask

  initial begin
    int ph, k, n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed requests under the reset register values
    offer(REQ_UPDATE, 16'd0, 14'd0);
    offer(REQ_UPDATE, 16'd32768, 14'd0);
    offer(REQ_UPDATE, 16'd32768, 14'd0);
    offer(REQ_UPDATE, 16'd1, 14'h3FFF);
    offer(REQ_UPDATE, 16'hFFFF, 14'h1555);
    offer(REQ_UPDATE, 16'd32769, 14'h2AAA);
    offer(REQ_UPDATE, 16'h5555, 14'd100);
    offer(REQ_UPDATE, 16'hAAAA, 14'd1);
    offer(REQ_UPDATE, 16'd16384, 14'd0);
    offer(REQ_INVALIDATE, 16'hFFFF, 14'h3FFF);
    offer(REQ_UPDATE, 16'd16384, 14'd0);
    offer(REQ_INVALIDATE, 16'd0, 14'd0);
    offer(REQ_RESET, 16'd0, 14'd0);
    offer(REQ_RESET, 16'd1234, 14'd77);
    offer(REQ_SPARE, 16'd0, 14'd0);
    offer(REQ_UPDATE, 16'd1, 14'd0);
    offer(REQ_UPDATE, 16'd2, 14'h3FFF);
    offer(REQ_SPARE, 16'h1234, 14'h0F0F);

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: apply_setting(-32768, -32768, 8192, 1023, 0);
        1: apply_setting(0, -8192, 8192, 1, 1);
        2: apply_setting(-24576, -4096, -8192, 500, 3);
        3: apply_setting(-16384, -15360, 0, 1023, 1023);
        4: apply_setting(-8000, -8192, -8192, 300, 2);
        5: apply_setting(256, 0, 8192, 640, 5);
        6: apply_setting(-20000, -30000, 100, 37, 5);
        default: apply_setting(-24576, -15360, 1536, 200, 2);
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        n = ph * PHASE_ITEMS + k;
        if (n == 0) begin
          src_idle = 8;
          sink_idle <= 84;
        end else if (n == 267) begin
          src_idle = 84;
          sink_idle <= 8;
        end else if (n == 534) begin
          src_idle = 0;
          sink_idle <= 0;
        end
        if (n == 150) drain();
        if (n == 650) stall_req <= 1'b1;
        random_item();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
